[rtl/asd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asd_pkg
// Shared types and constants for the arithmetic symbol decoder.
// ----------------------------------------------------------------------------
package asd_pkg;

    localparam int CODE_BITS        = 16;
    localparam int KIND_W           = 2;
    localparam int INDEX_W          = 9;
    localparam int ENTRY_W          = 15;
    localparam int BYTE_W           = 8;
    localparam int SYM_W            = 8;
    localparam int STAT_W           = 2;
    localparam int CFG_W            = 9;
    localparam int SYMBOLS_DEF      = 256;
    localparam int BUFFER_BYTES_DEF = 4096;
    localparam int WID_W            = CODE_BITS + 1;
    localparam int PROD_W           = WID_W + ENTRY_W;
    localparam int FILL_W           = $clog2(CODE_BITS);

    localparam logic [CFG_W-1:0]     SYMCNT_RESET = CFG_W'(256);
    localparam logic [CODE_BITS-1:0] HALF_VAL = CODE_BITS'(1) << (CODE_BITS - 1);
    localparam logic [CODE_BITS-1:0] QTR1_VAL = CODE_BITS'(1) << (CODE_BITS - 2);
    localparam logic [CODE_BITS-1:0] QTR3_VAL = HALF_VAL + QTR1_VAL;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE_ENTRY = 2'd0,
        KIND_APPEND      = 2'd1,
        KIND_START       = 2'd2,
        KIND_DECODE      = 2'd3
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_DROP  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_VALUE,
        PH_HI,
        PH_LO
    } div_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL_RD,
        ST_FILL_SH,
        ST_TOT_RD,
        ST_TOT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SCAN_PRIME,
        ST_SCAN,
        ST_MUL_LO,
        ST_NARROW,
        ST_RN_CHK,
        ST_RN_BIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] entry_index;
        logic [ENTRY_W-1:0] entry_value;
        logic [BYTE_W-1:0]  byte_value;
    } cmd_t;

    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [STAT_W-1:0] status;
    } rsp_t;

endpackage
`default_nettype wire

[rtl/asd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module asd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/asd_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asd_div #(
    parameter int DVD_W = asd_pkg::PROD_W,
    parameter int DVS_W = asd_pkg::WID_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic      [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        ge    = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

[rtl/arithmetic_symbol_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arithmetic_symbol_decoder
// Integer arithmetic decoder: table load, byte buffer, start and decode.
// ----------------------------------------------------------------------------
//  channel | signals                          | role
//  cmd     | cmd_valid, cmd_stall, cmd        | request in: kind and its fields
//  rsp     | rsp_valid, rsp_stall, rsp        | one result per request
//  cfg     | cfg_wr_en, cfg_wr_data           | symbol_count register
//
//  Table write and byte append go straight to the response. Start loads
//  CODE_BITS code bits, each a byte RAM read and then a shift. Decode time
//  grows with the symbol index and the renormalization bits; the serial divider
//  (one quotient bit a cycle, three divisions) and the linear table scan set it.
//  Reset is asynchronous; both RAMs come up undefined, no clearing pass.
//  cmd_stall is high while a request is in work; rsp holds under rsp_stall.
// ----------------------------------------------------------------------------
module arithmetic_symbol_decoder #(
    parameter int SYMBOLS      = asd_pkg::SYMBOLS_DEF,
    parameter int BUFFER_BYTES = asd_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_stall,
    input  wire asd_pkg::cmd_t               cmd,
    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    output asd_pkg::rsp_t                    rsp,
    input  wire logic                        cfg_wr_en,
    input  wire logic [asd_pkg::CFG_W-1:0]   cfg_wr_data
);

    localparam int CB    = asd_pkg::CODE_BITS;
    localparam int TI_W  = $clog2(SYMBOLS + 1);
    localparam int BA_W  = $clog2(BUFFER_BYTES);
    localparam int HB_W  = $clog2(BUFFER_BYTES + 1);
    localparam int POS_W = $clog2(BUFFER_BYTES * 8 + 1);
    localparam int NW    = asd_pkg::PROD_W + 1;

    asd_pkg::state_t     state_reg, state_next;
    asd_pkg::div_phase_t phase_reg;

    logic [asd_pkg::CFG_W-1:0]   symcnt_reg;
    logic [CB-1:0]               lo_reg, hi_reg, cw_reg;
    logic [HB_W-1:0]             held_reg;
    logic [POS_W-1:0]            pos_reg;
    logic [asd_pkg::FILL_W-1:0]  fill_reg;
    logic [asd_pkg::ENTRY_W-1:0] total_reg, clo_reg, prev_reg;
    logic [asd_pkg::PROD_W-1:0]  prod_reg, value_reg, qhi_reg;
    logic [TI_W-1:0]             chk_reg;
    logic [asd_pkg::SYM_W-1:0]   res_sym_reg;
    logic [asd_pkg::STAT_W-1:0]  res_stat_reg;
    logic                        rsp_valid_reg;
    asd_pkg::rsp_t               rsp_reg;

    logic                        accept;
    logic                        full;
    logic [TI_W-1:0]             n_sym;
    logic [asd_pkg::WID_W-1:0]   width;
    logic [asd_pkg::WID_W-1:0]   mul_a;
    logic [asd_pkg::ENTRY_W-1:0] mul_b;
    logic                        bit_avail;
    logic                        bit_in;

    // table RAM
    logic                        tbl_we;
    logic [TI_W-1:0]             tbl_raddr;
    logic [asd_pkg::ENTRY_W-1:0] tbl_rdata;
    // byte RAM
    logic                        byte_we;
    logic [asd_pkg::BYTE_W-1:0]  byte_rdata;

    // divider
    logic                        div_start;
    logic                        div_done;
    logic [asd_pkg::PROD_W-1:0]  div_dvd;
    logic [asd_pkg::WID_W-1:0]   div_dvs;
    logic [asd_pkg::PROD_W-1:0]  div_q;

    // renormalization step
    logic                        rn_go;
    logic [CB-1:0]               rn_sub;
    // narrowing
    logic [NW-1:0]               nhi_w, nlo_w, nhi1_w, cw_w;

    assign accept    = cmd_valid && !cmd_stall;
    assign full      = held_reg == HB_W'(BUFFER_BYTES);
    assign width     = {1'b0, hi_reg} - {1'b0, lo_reg} + 1'b1;
    assign bit_avail = pos_reg < POS_W'({held_reg, 3'b000});
    assign bit_in    = bit_avail && byte_rdata[3'd7 - pos_reg[2:0]];

    always_comb
    begin
        if (32'(symcnt_reg) > SYMBOLS)
        begin
            n_sym = TI_W'(SYMBOLS);
        end
        else if (symcnt_reg < asd_pkg::CFG_W'(2))
        begin
            n_sym = TI_W'(2);
        end
        else
        begin
            n_sym = TI_W'(symcnt_reg);
        end
    end

    assign tbl_we  = accept && (cmd.kind == asd_pkg::KIND_WRITE_ENTRY)
                     && (32'(cmd.entry_index) <= SYMBOLS);
    assign byte_we = accept && (cmd.kind == asd_pkg::KIND_APPEND) && !full;

    always_comb
    begin
        unique case (state_reg)
            asd_pkg::ST_SCAN_PRIME: tbl_raddr = '0;
            asd_pkg::ST_SCAN:       tbl_raddr = (chk_reg == n_sym) ? chk_reg
                                                                   : chk_reg + 1'b1;
            default:                tbl_raddr = n_sym;
        endcase
    end

    asd_ram #(
        .WIDTH (asd_pkg::ENTRY_W),
        .DEPTH (SYMBOLS + 1)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (TI_W'(cmd.entry_index)),
        .wdata (cmd.entry_value),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    asd_ram #(
        .WIDTH (asd_pkg::BYTE_W),
        .DEPTH (BUFFER_BYTES)
    ) u_bytes (
        .clk   (clk),
        .we    (byte_we),
        .waddr (held_reg[BA_W-1:0]),
        .wdata (cmd.byte_value),
        .raddr (pos_reg[BA_W+2:3]),
        .rdata (byte_rdata)
    );

    // shared multiplier operands
    always_comb
    begin
        unique case (state_reg)
            asd_pkg::ST_TOT:
            begin
                mul_a = {1'b0, cw_reg} - {1'b0, lo_reg} + 1'b1;
                mul_b = tbl_rdata;
            end
            asd_pkg::ST_MUL_LO:
            begin
                mul_a = width;
                mul_b = clo_reg;
            end
            default:
            begin
                mul_a = width;
                mul_b = tbl_rdata;
            end
        endcase
    end

    assign div_start = state_reg == asd_pkg::ST_DIV_GO;
    assign div_dvd   = (phase_reg == asd_pkg::PH_VALUE) ? prod_reg - 1'b1 : prod_reg;
    assign div_dvs   = (phase_reg == asd_pkg::PH_VALUE) ? width
                                                        : asd_pkg::WID_W'(total_reg);

    asd_div #(
        .DVD_W (asd_pkg::PROD_W),
        .DVS_W (asd_pkg::WID_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // narrowed interval from the two quotients
    always_comb
    begin
        nhi_w  = NW'(lo_reg) + NW'(qhi_reg);
        nlo_w  = NW'(lo_reg) + NW'(div_q);
        nhi1_w = nhi_w - 1'b1;
        cw_w   = NW'(cw_reg);
    end

    // half and quarter rules
    always_comb
    begin
        priority if (hi_reg < asd_pkg::HALF_VAL)
        begin
            rn_go  = 1'b1;
            rn_sub = '0;
        end
        else if (lo_reg >= asd_pkg::HALF_VAL)
        begin
            rn_go  = 1'b1;
            rn_sub = asd_pkg::HALF_VAL;
        end
        else if (lo_reg >= asd_pkg::QTR1_VAL && hi_reg < asd_pkg::QTR3_VAL)
        begin
            rn_go  = 1'b1;
            rn_sub = asd_pkg::QTR1_VAL;
        end
        else
        begin
            rn_go  = 1'b0;
            rn_sub = '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            asd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.kind)
                        asd_pkg::KIND_START:  state_next = asd_pkg::ST_FILL_RD;
                        asd_pkg::KIND_DECODE: state_next = asd_pkg::ST_TOT_RD;
                        default:              state_next = asd_pkg::ST_DONE;
                    endcase
                end
            end
            asd_pkg::ST_FILL_RD: state_next = asd_pkg::ST_FILL_SH;
            asd_pkg::ST_FILL_SH:
            begin
                state_next = (fill_reg == asd_pkg::FILL_W'(CB - 1)) ? asd_pkg::ST_DONE
                                                                    : asd_pkg::ST_FILL_RD;
            end
            asd_pkg::ST_TOT_RD: state_next = asd_pkg::ST_TOT;
            asd_pkg::ST_TOT:
            begin
                if (tbl_rdata == '0 || hi_reg < lo_reg || cw_reg < lo_reg
                    || cw_reg > hi_reg)
                begin
                    state_next = asd_pkg::ST_DONE;
                end
                else
                begin
                    state_next = asd_pkg::ST_DIV_GO;
                end
            end
            asd_pkg::ST_DIV_GO: state_next = asd_pkg::ST_DIV_WAIT;
            asd_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    unique case (phase_reg)
                        asd_pkg::PH_VALUE: state_next = asd_pkg::ST_SCAN_PRIME;
                        asd_pkg::PH_HI:    state_next = asd_pkg::ST_MUL_LO;
                        default:           state_next = asd_pkg::ST_NARROW;
                    endcase
                end
            end
            asd_pkg::ST_SCAN_PRIME: state_next = asd_pkg::ST_SCAN;
            asd_pkg::ST_SCAN:
            begin
                if (asd_pkg::PROD_W'(tbl_rdata) > value_reg)
                begin
                    state_next = (chk_reg == '0 || tbl_rdata > total_reg)
                                 ? asd_pkg::ST_DONE : asd_pkg::ST_DIV_GO;
                end
                else if (chk_reg == n_sym)
                begin
                    state_next = asd_pkg::ST_DONE;
                end
            end
            asd_pkg::ST_MUL_LO: state_next = asd_pkg::ST_DIV_GO;
            asd_pkg::ST_NARROW:
            begin
                if (nhi_w == '0 || nlo_w > nhi1_w || cw_w < nlo_w || cw_w > nhi1_w)
                begin
                    state_next = asd_pkg::ST_DONE;
                end
                else
                begin
                    state_next = asd_pkg::ST_RN_CHK;
                end
            end
            asd_pkg::ST_RN_CHK:
            begin
                state_next = rn_go ? asd_pkg::ST_RN_BIT : asd_pkg::ST_DONE;
            end
            asd_pkg::ST_RN_BIT: state_next = asd_pkg::ST_RN_CHK;
            asd_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = asd_pkg::ST_IDLE;
                end
            end
            default: state_next = asd_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_stall = state_reg != asd_pkg::ST_IDLE;
        rsp_valid = rsp_valid_reg;
        rsp       = rsp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= asd_pkg::ST_IDLE;
            symcnt_reg    <= asd_pkg::SYMCNT_RESET;
            lo_reg        <= '0;
            hi_reg        <= '1;
            cw_reg        <= '0;
            held_reg      <= '0;
            pos_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                symcnt_reg <= cfg_wr_data;
            end
            if (byte_we)
            begin
                held_reg <= held_reg + 1'b1;
            end
            if (accept && cmd.kind == asd_pkg::KIND_START)
            begin
                lo_reg  <= '0;
                hi_reg  <= '1;
                cw_reg  <= '0;
                pos_reg <= '0;
            end
            if (state_reg == asd_pkg::ST_FILL_SH || state_reg == asd_pkg::ST_RN_BIT)
            begin
                cw_reg  <= {cw_reg[CB-2:0], bit_in};
                pos_reg <= pos_reg + POS_W'(bit_avail);
            end
            if (state_reg == asd_pkg::ST_NARROW && state_next == asd_pkg::ST_RN_CHK)
            begin
                lo_reg <= nlo_w[CB-1:0];
                hi_reg <= nhi1_w[CB-1:0];
            end
            if (state_reg == asd_pkg::ST_RN_CHK && rn_go)
            begin
                lo_reg <= {lo_reg[CB-2:0] - rn_sub[CB-2:0], 1'b0};
                hi_reg <= {hi_reg[CB-2:0] - rn_sub[CB-2:0], 1'b1};
                cw_reg <= cw_reg - rn_sub;
            end
            // a new response replaces the one taken this cycle
            if (state_reg == asd_pkg::ST_DONE && (!rsp_valid_reg || !rsp_stall))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= asd_pkg::PROD_W'(mul_a) * asd_pkg::PROD_W'(mul_b);
        if (accept)
        begin
            res_sym_reg  <= '0;
            res_stat_reg <= (cmd.kind == asd_pkg::KIND_APPEND && full)
                            ? asd_pkg::STAT_DROP : asd_pkg::STAT_OK;
            fill_reg     <= '0;
        end
        if (state_reg == asd_pkg::ST_FILL_SH)
        begin
            fill_reg <= fill_reg + 1'b1;
        end
        if (state_reg == asd_pkg::ST_TOT)
        begin
            total_reg <= tbl_rdata;
            phase_reg <= asd_pkg::PH_VALUE;
            if (state_next == asd_pkg::ST_DONE)
            begin
                res_stat_reg <= asd_pkg::STAT_RANGE;
            end
        end
        if (state_reg == asd_pkg::ST_DIV_WAIT && div_done)
        begin
            if (phase_reg == asd_pkg::PH_VALUE)
            begin
                value_reg <= div_q;
            end
            if (phase_reg == asd_pkg::PH_HI)
            begin
                qhi_reg <= div_q;
            end
        end
        if (state_reg == asd_pkg::ST_SCAN_PRIME)
        begin
            chk_reg <= '0;
        end
        if (state_reg == asd_pkg::ST_SCAN)
        begin
            prev_reg <= tbl_rdata;
            if (asd_pkg::PROD_W'(tbl_rdata) > value_reg)
            begin
                clo_reg   <= prev_reg;
                phase_reg <= asd_pkg::PH_HI;
            end
            else if (chk_reg != n_sym)
            begin
                chk_reg <= chk_reg + 1'b1;
            end
            if (state_next == asd_pkg::ST_DONE)
            begin
                res_stat_reg <= asd_pkg::STAT_RANGE;
            end
        end
        if (state_reg == asd_pkg::ST_MUL_LO)
        begin
            phase_reg <= asd_pkg::PH_LO;
        end
        if (state_reg == asd_pkg::ST_NARROW)
        begin
            if (state_next == asd_pkg::ST_DONE)
            begin
                res_stat_reg <= asd_pkg::STAT_RANGE;
            end
            else
            begin
                res_sym_reg <= asd_pkg::SYM_W'(chk_reg - 1'b1);
            end
        end
        if (state_reg == asd_pkg::ST_DONE && (!rsp_valid_reg || !rsp_stall))
        begin
            rsp_reg.symbol <= res_sym_reg;
            rsp_reg.status <= res_stat_reg;
        end
    end

`ifndef SYNTHESIS
    // A failed or non-decode request never carries a symbol.
    a_sym_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != asd_pkg::STAT_OK) |-> rsp.symbol == '0)
        else $error("nonzero symbol with error status");

    // Between requests the interval is ordered and holds the code.
    a_interval_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == asd_pkg::ST_IDLE) |->
        (lo_reg <= hi_reg && cw_reg >= lo_reg && cw_reg <= hi_reg))
        else $error("interval broken between requests");

    // Buffer fill and read position stay within the stored bytes.
    a_buffer_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg <= HB_W'(BUFFER_BYTES)) && (pos_reg <= POS_W'({held_reg, 3'b000})))
        else $error("byte buffer bounds violated");

    // Divider completion only lands while the sequencer waits for it.
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == asd_pkg::ST_DIV_WAIT)
        else $error("divider done outside wait state");
`endif

endmodule
`default_nettype wire
